// ===== hdl/i2c_rts_pkg.sv =====
// ----------------------------------------------------------------------------
// i2c register transaction sequencer package
// Shared codes, phase type and result word layout for the sequencer.
// ----------------------------------------------------------------------------
package i2c_rts_pkg;

  // register reset values and widths
  localparam logic [15:0] TimeoutReset = 16'd1000;
  localparam int unsigned InDataW      = 56;
  localparam int unsigned OutDataW     = 24;

  // engine status handling
  localparam logic [7:0] StatusMask   = 8'hF8;
  localparam logic [7:0] StStart      = 8'h08;
  localparam logic [7:0] StRestart    = 8'h10;
  localparam logic [7:0] StAddrWAck   = 8'h18;
  localparam logic [7:0] StWDataAck   = 8'h28;
  localparam logic [7:0] StAddrRAck   = 8'h40;
  localparam logic [7:0] StRDataAck   = 8'h50;
  localparam logic [7:0] StRDataNack  = 8'h58;

  // request kinds
  typedef enum logic [2:0] {
    REQ_READ   = 3'd0,
    REQ_WRITE  = 3'd1,
    REQ_STATUS = 3'd2,
    REQ_TICK   = 3'd3,
    REQ_WBYTE  = 3'd4
  } req_e;

  // engine commands
  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_SEND    = 3'd2,
    CMD_RX_ACK  = 3'd3,
    CMD_RX_NACK = 3'd4,
    CMD_STOP    = 3'd5
  } cmd_e;

  // completion status
  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_TIMEOUT = 2'd1,
    ERR_REJECT  = 2'd2
  } err_e;

  // transaction phase
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_START   = 4'd1,
    PH_ADDR_W  = 4'd2,
    PH_REG     = 4'd3,
    PH_RESTART = 4'd4,
    PH_ADDR_R  = 4'd5,
    PH_RX_ACK  = 4'd6,
    PH_RX_NACK = 4'd7,
    PH_NEED    = 4'd8,
    PH_WDATA   = 4'd9
  } phase_e;

  // one result word
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       need_byte;
    logic       done_res;
    err_e       error_code;
  } res_t;

endpackage

// ===== hdl/i2c_register_transaction_sequencer.sv =====
// ----------------------------------------------------------------------------
// i2c register transaction sequencer
// Turns register read/write requests and engine events into byte-level
// engine commands, received bytes and completion status.
// ----------------------------------------------------------------------------
//
//  channel   | direction | tuser       | tdata (low bit first)
//  s_axis    | in        | req_type    | dev_addr, reg_addr, length, status_code,
//            |           |             | rx_data, write_byte, pad
//  m_axis    | out       | engine_cmd  | tx_byte, rx_valid, rx_byte, need_byte,
//            |           |             | done_res, error_code, pad
//  cfg       | in        | -           | timeout_ticks
//
//  Each word is decoded in the decode stage; one word per cycle is
//  sustained unless a stalled result holds it, and the result register loads
//  from the decode of the word held in the input register.
//  The input register and the result register are the only storage on the
//  path; a stalled result stalls the input register only for words that
//  produce a result. Reset clears phase, counters and both valid flags and
//  loads timeout_ticks with 1000.
//
module i2c_register_transaction_sequencer
  import i2c_rts_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,    // timeout_ticks
  // request stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // dev_addr, reg_addr, length, status_code,
                                              // rx_data, write_byte, one pad bit
  input  logic [2:0]          s_axis_tuser,   // req_type
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // tx_byte, rx_valid, rx_byte, need_byte,
                                              // done_res, error_code, three pad bits
  output logic [2:0]          m_axis_tuser    // engine_cmd
);

  // configuration register
  logic [15:0] timeout_q;

  // input register
  logic              in_vld_q;
  logic [2:0]        in_req_q;
  logic [InDataW-1:0] in_data_q;

  // sequencer state
  phase_e      phase_q, phase_d;
  logic        is_read_q, is_read_d;
  logic [6:0]  addr_q, addr_d;
  logic [7:0]  reg_q, reg_d;
  logic [15:0] left_q, left_d;
  logic [15:0] wait_q, wait_d;

  // result register
  logic out_vld_q;
  res_t out_q;

  // decode-stage signals
  logic [6:0]  f_dev;
  logic [7:0]  f_reg;
  logic [15:0] f_len;
  logic [7:0]  f_status;
  logic [7:0]  f_rx;
  logic [7:0]  f_wbyte;
  logic [7:0]  st;
  logic [15:0] wait_inc;
  logic        has_res;
  res_t        res;
  logic        advance;
  logic        out_free;

  assign f_dev    = in_data_q[6:0];
  assign f_reg    = in_data_q[14:7];
  assign f_len    = in_data_q[30:15];
  assign f_status = in_data_q[38:31];
  assign f_rx     = in_data_q[46:39];
  assign f_wbyte  = in_data_q[54:47];
  assign st       = f_status & StatusMask;
  assign wait_inc = wait_q + 16'd1;

  // handshake between stages
  assign out_free      = !out_vld_q || m_axis_tready;
  assign advance       = in_vld_q && (!has_res || out_free);
  assign s_axis_tready = !in_vld_q || advance;

  // configuration write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_req_q  <= s_axis_tuser;
      in_data_q <= s_axis_tdata;
    end
  end

  // next phase and result for the word in the input register
  always_comb begin
    phase_d   = phase_q;
    is_read_d = is_read_q;
    addr_d    = addr_q;
    reg_d     = reg_q;
    left_d    = left_q;
    wait_d    = wait_q;
    has_res   = 1'b0;
    res       = '{cmd: CMD_NONE, tx_byte: 8'd0, rx_valid: 1'b0, rx_byte: 8'd0,
                  need_byte: 1'b0, done_res: 1'b0, error_code: ERR_OK};
    case (in_req_q)
      REQ_READ, REQ_WRITE: begin
        has_res = 1'b1;
        if (phase_q != PH_IDLE || (in_req_q == REQ_READ && f_len == 16'd0)) begin
          res.done_res   = 1'b1;
          res.error_code = ERR_REJECT;
        end else begin
          is_read_d = (in_req_q == REQ_READ);
          addr_d    = f_dev;
          reg_d     = f_reg;
          left_d    = f_len;
          phase_d   = PH_START;
          wait_d    = 16'd0;
          res.cmd   = CMD_START;
        end
      end
      REQ_STATUS: begin
        case (phase_q)
          PH_START: if (st == StStart) begin
            has_res     = 1'b1;
            phase_d     = PH_ADDR_W;
            wait_d      = 16'd0;
            res.cmd     = CMD_SEND;
            res.tx_byte = {addr_q, 1'b0};
          end
          PH_ADDR_W: if (st == StAddrWAck) begin
            has_res     = 1'b1;
            phase_d     = PH_REG;
            wait_d      = 16'd0;
            res.cmd     = CMD_SEND;
            res.tx_byte = reg_q;
          end
          PH_REG, PH_WDATA: if (st == StWDataAck) begin
            has_res = 1'b1;
            wait_d  = 16'd0;
            if (phase_q == PH_REG && is_read_q) begin
              phase_d = PH_RESTART;
              res.cmd = CMD_START;
            end else if (left_q == 16'd0) begin
              phase_d      = PH_IDLE;
              res.cmd      = CMD_STOP;
              res.done_res = 1'b1;
            end else begin
              phase_d       = PH_NEED;
              res.need_byte = 1'b1;
            end
          end
          PH_RESTART: if (st == StRestart) begin
            has_res     = 1'b1;
            phase_d     = PH_ADDR_R;
            wait_d      = 16'd0;
            res.cmd     = CMD_SEND;
            res.tx_byte = {addr_q, 1'b1};
          end
          PH_ADDR_R: if (st == StAddrRAck) begin
            has_res = 1'b1;
            wait_d  = 16'd0;
            if (left_q > 16'd1) begin
              phase_d = PH_RX_ACK;
              res.cmd = CMD_RX_ACK;
            end else begin
              phase_d = PH_RX_NACK;
              res.cmd = CMD_RX_NACK;
            end
          end
          PH_RX_ACK: if (st == StRDataAck) begin
            has_res      = 1'b1;
            wait_d       = 16'd0;
            left_d       = left_q - 16'd1;
            res.rx_valid = 1'b1;
            res.rx_byte  = f_rx;
            // decide on the count after this byte
            if (left_d > 16'd1) begin
              phase_d = PH_RX_ACK;
              res.cmd = CMD_RX_ACK;
            end else begin
              phase_d = PH_RX_NACK;
              res.cmd = CMD_RX_NACK;
            end
          end
          PH_RX_NACK: if (st == StRDataNack) begin
            has_res      = 1'b1;
            wait_d       = 16'd0;
            left_d       = 16'd0;
            phase_d      = PH_IDLE;
            res.cmd      = CMD_STOP;
            res.rx_valid = 1'b1;
            res.rx_byte  = f_rx;
            res.done_res = 1'b1;
          end
          default: ;
        endcase
      end
      REQ_TICK: begin
        // count only while an engine status is awaited
        if (phase_q != PH_IDLE && phase_q != PH_NEED) begin
          wait_d = wait_inc;
          if (wait_inc >= timeout_q || wait_inc == 16'd0) begin
            has_res        = 1'b1;
            phase_d        = PH_IDLE;
            wait_d         = 16'd0;
            res.cmd        = CMD_STOP;
            res.done_res   = 1'b1;
            res.error_code = ERR_TIMEOUT;
          end
        end
      end
      REQ_WBYTE: begin
        if (phase_q == PH_NEED) begin
          has_res     = 1'b1;
          left_d      = left_q - 16'd1;
          phase_d     = PH_WDATA;
          wait_d      = 16'd0;
          res.cmd     = CMD_SEND;
          res.tx_byte = f_wbyte;
        end
      end
      default: ;
    endcase
  end

  // sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      is_read_q <= 1'b0;
      addr_q    <= 7'd0;
      reg_q     <= 8'd0;
      left_q    <= 16'd0;
      wait_q    <= 16'd0;
    end else if (advance) begin
      phase_q   <= phase_d;
      is_read_q <= is_read_d;
      addr_q    <= addr_d;
      reg_q     <= reg_d;
      left_q    <= left_d;
      wait_q    <= wait_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && has_res) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && has_res) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.cmd;
  assign m_axis_tdata  = {3'b000, out_q.error_code, out_q.done_res, out_q.need_byte,
                          out_q.rx_byte, out_q.rx_valid, out_q.tx_byte};

`ifndef SYNTHESIS
  // a finished or aborted transaction leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && has_res && res.done_res && res.error_code != ERR_REJECT)
      |=> (phase_q == PH_IDLE))
    else $error("sequencer not idle after transaction end");

  // no tick count while waiting for a host byte
  a_need_no_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_NEED) |-> (wait_q == 16'd0))
    else $error("wait counter running while waiting for host byte");

  // acked receive only while more than one byte remains
  a_rx_ack_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_RX_ACK) |-> (left_q > 16'd1))
    else $error("acked receive with one byte or fewer left");

  // a held input word is not overwritten
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !advance) |=> (in_vld_q && $stable(in_data_q) && $stable(in_req_q)))
    else $error("stalled input word changed");
`endif

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// i2c register transaction sequencer testbench
// Drives register reads, writes, engine status events, ticks and host bytes
// into the sequencer with random gaps and back-pressure. A scoreboard
// predicts every engine command, read byte and completion word, and compares
// each result word in order. The timeout register is rewritten between
// phases.
// ----------------------------------------------------------------------------
module testbench;
  import i2c_rts_pkg::*;

  localparam int unsigned CycleLimit      = 400000;
  localparam int unsigned ItemsPerSetting = 175;
  localparam int unsigned HoldCycles      = 300;
  localparam int unsigned DrainCycles     = 6;

  // one request word, unpacked
  typedef struct {
    logic [2:0]  kind;
    logic [6:0]  dev;
    logic [7:0]  regi;
    logic [15:0] len;
    logic [7:0]  status;
    logic [7:0]  rxd;
    logic [7:0]  wbyte;
  } req_word_t;

  // sequencer predictor and in-order result checker
  class txn_scoreboard;
    phase_e      phase;
    bit          is_read;
    logic [6:0]  dev_addr;
    logic [7:0]  reg_idx;
    logic [15:0] bytes_left;
    logic [15:0] wait_count;
    logic [15:0] timeout_ticks;
    res_t        expected_q[$];
    int unsigned mismatches;

    function new();
      phase         = PH_IDLE;
      is_read       = 1'b0;
      dev_addr      = '0;
      reg_idx       = '0;
      bytes_left    = '0;
      wait_count    = '0;
      timeout_ticks = TimeoutReset;
      mismatches    = 0;
    endfunction

    function void enter(phase_e next);
      phase      = next;
      wait_count = '0;
    endfunction

    function res_t quiet_word();
      res_t r;
      r.cmd        = CMD_NONE;
      r.tx_byte    = '0;
      r.rx_valid   = 1'b0;
      r.rx_byte    = '0;
      r.need_byte  = 1'b0;
      r.done_res   = 1'b0;
      r.error_code = ERR_OK;
      return r;
    endfunction

    function cmd_e next_receive();
      if (bytes_left > 16'd1) begin
        enter(PH_RX_ACK);
        return CMD_RX_ACK;
      end
      enter(PH_RX_NACK);
      return CMD_RX_NACK;
    endfunction

    // register index or data byte acked in a write: stop or ask for a byte
    function res_t after_write_ack();
      res_t r;
      r = quiet_word();
      if (bytes_left == 16'd0) begin
        enter(PH_IDLE);
        r.cmd      = CMD_STOP;
        r.done_res = 1'b1;
      end else begin
        enter(PH_NEED);
        r.need_byte = 1'b1;
      end
      return r;
    endfunction

    // accepted request word: update state, queue the word it causes
    function void advance(req_word_t w);
      res_t       r;
      bit         emit;
      logic [7:0] s;
      r    = quiet_word();
      emit = 1'b0;
      s    = w.status & StatusMask;
      case (w.kind)
        REQ_READ, REQ_WRITE: begin
          emit = 1'b1;
          if (phase != PH_IDLE || (w.kind == REQ_READ && w.len == 16'd0)) begin
            r.done_res   = 1'b1;
            r.error_code = ERR_REJECT;
          end else begin
            is_read    = (w.kind == REQ_READ);
            dev_addr   = w.dev;
            reg_idx    = w.regi;
            bytes_left = w.len;
            enter(PH_START);
            r.cmd = CMD_START;
          end
        end
        REQ_STATUS: begin
          case (phase)
            PH_START: if (s == StStart) begin
              enter(PH_ADDR_W);
              r.cmd     = CMD_SEND;
              r.tx_byte = {dev_addr, 1'b0};
              emit      = 1'b1;
            end
            PH_ADDR_W: if (s == StAddrWAck) begin
              enter(PH_REG);
              r.cmd     = CMD_SEND;
              r.tx_byte = reg_idx;
              emit      = 1'b1;
            end
            PH_REG: if (s == StWDataAck) begin
              emit = 1'b1;
              if (is_read) begin
                enter(PH_RESTART);
                r.cmd = CMD_START;
              end else begin
                r = after_write_ack();
              end
            end
            PH_RESTART: if (s == StRestart) begin
              enter(PH_ADDR_R);
              r.cmd     = CMD_SEND;
              r.tx_byte = {dev_addr, 1'b1};
              emit      = 1'b1;
            end
            PH_ADDR_R: if (s == StAddrRAck) begin
              r.cmd = next_receive();
              emit  = 1'b1;
            end
            PH_RX_ACK: if (s == StRDataAck) begin
              bytes_left = bytes_left - 16'd1;
              r.cmd      = next_receive();
              r.rx_valid = 1'b1;
              r.rx_byte  = w.rxd;
              emit       = 1'b1;
            end
            PH_RX_NACK: if (s == StRDataNack) begin
              bytes_left = '0;
              enter(PH_IDLE);
              r.cmd      = CMD_STOP;
              r.rx_valid = 1'b1;
              r.rx_byte  = w.rxd;
              r.done_res = 1'b1;
              emit       = 1'b1;
            end
            PH_WDATA: if (s == StWDataAck) begin
              r    = after_write_ack();
              emit = 1'b1;
            end
            default: ;
          endcase
        end
        REQ_TICK: begin
          // ticks only count while an engine status is awaited
          if (phase != PH_IDLE && phase != PH_NEED) begin
            wait_count = wait_count + 16'd1;
            if (wait_count >= timeout_ticks || wait_count == 16'd0) begin
              enter(PH_IDLE);
              r.cmd        = CMD_STOP;
              r.done_res   = 1'b1;
              r.error_code = ERR_TIMEOUT;
              emit         = 1'b1;
            end
          end
        end
        REQ_WBYTE: begin
          if (phase == PH_NEED) begin
            bytes_left = bytes_left - 16'd1;
            enter(PH_WDATA);
            r.cmd     = CMD_SEND;
            r.tx_byte = w.wbyte;
            emit      = 1'b1;
          end
        end
        default: ;
      endcase
      if (emit) expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
      if (act_val !== exp_val) begin
        $error("%s: expected %0h, got %0h", name, exp_val, act_val);
        mismatches++;
      end
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected: cmd %0h", got.cmd);
        mismatches++;
        return;
      end
      e = expected_q.pop_front();
      compare_field("engine_cmd", 8'(e.cmd), 8'(got.cmd));
      compare_field("tx_byte", e.tx_byte, got.tx_byte);
      compare_field("rx_valid", 8'(e.rx_valid), 8'(got.rx_valid));
      compare_field("rx_byte", e.rx_byte, got.rx_byte);
      compare_field("need_byte", 8'(e.need_byte), 8'(got.need_byte));
      compare_field("done_res", 8'(e.done_res), 8'(got.done_res));
      compare_field("error_code", 8'(e.error_code), 8'(got.error_code));
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [15:0]         cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;   // dev_addr, reg_addr, length, status_code,
                                       // rx_data, write_byte, one pad bit
  logic [2:0]          s_axis_tuser;   // req_type
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // tx_byte, rx_valid, rx_byte, need_byte,
                                       // done_res, error_code, three pad bits
  logic [2:0]          m_axis_tuser;   // engine_cmd

  txn_scoreboard sb;
  bit            idling       = 1'b1;
  bit            hold_off_req = 1'b0;

  logic [15:0] timeout_plan [6] = '{16'd65535, 16'd1, 16'd6, 16'd1000, 16'd3, 16'd40};

  i2c_register_transaction_sequencer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // offer one word after a random gap, note it once accepted
  task automatic offer_word(req_word_t w);
    int unsigned gap;
    gap = idling ? $urandom_range(0, 7) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = w.kind;
    s_axis_tdata  = {1'b0, w.wbyte, w.rxd, w.status, w.len, w.regi, w.dev};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.advance(w);
  endtask

  task automatic offer_fields(logic [2:0] kind, logic [6:0] dev, logic [7:0] regi,
                              logic [15:0] len, logic [7:0] status, logic [7:0] rxd,
                              logic [7:0] wbyte);
    req_word_t w;
    w = '{kind, dev, regi, len, status, rxd, wbyte};
    offer_word(w);
  endtask

  // stop offering and let every expected word and the pipeline drain
  task automatic wait_for_results();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_timeout(logic [15:0] value);
    wait_for_results();
    cfg_wdata_i = value;
    cfg_we_i    = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.timeout_ticks = value;
  endtask

  function automatic req_word_t random_word();
    req_word_t w;
    w.kind   = 3'($urandom_range(0, 7));
    w.dev    = 7'($urandom);
    w.regi   = 8'($urandom);
    w.len    = 16'($urandom);
    w.status = 8'($urandom);
    w.rxd    = 8'($urandom);
    w.wbyte  = 8'($urandom);
    return w;
  endfunction

  function automatic logic [7:0] awaited_status(phase_e ph);
    case (ph)
      PH_START:           return StStart;
      PH_ADDR_W:          return StAddrWAck;
      PH_REG, PH_WDATA:   return StWDataAck;
      PH_RESTART:         return StRestart;
      PH_ADDR_R:          return StAddrRAck;
      PH_RX_ACK:          return StRDataAck;
      PH_RX_NACK:         return StRDataNack;
      default:            return 8'h00;
    endcase
  endfunction

  // mostly the word that moves the transaction on, else ticks and noise
  function automatic req_word_t next_word();
    req_word_t   w;
    int unsigned roll;
    logic [7:0]  code;
    w    = random_word();
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      case (sb.phase)
        PH_IDLE: begin
          w.kind = $urandom_range(0, 1) ? REQ_READ : REQ_WRITE;
          w.len  = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(5, 24))
                                               : 16'($urandom_range(0, 4));
          if (w.kind == REQ_READ && w.len == 16'd0) w.len = 16'd1;
        end
        PH_NEED: w.kind = REQ_WBYTE;
        default: begin
          // low three status bits are don't-care
          code     = awaited_status(sb.phase);
          w.kind   = REQ_STATUS;
          w.status = {code[7:3], w.status[2:0]};
        end
      endcase
    end else if (roll < 90) begin
      w.kind = REQ_TICK;
    end else if (sb.phase == PH_IDLE && (w.kind == REQ_READ || w.kind == REQ_WRITE)) begin
      // keep accepted noise transactions short, zero-length reads still rejected
      w.len = 16'($urandom_range(0, 3));
    end
    return w;
  endfunction

  // result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int unsigned gap;
    res_t        got;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req  = 1'b0;
        m_axis_tready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      gap = idling ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
        m_axis_tready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got.cmd        = cmd_e'(m_axis_tuser);
      got.tx_byte    = m_axis_tdata[7:0];
      got.rx_valid   = m_axis_tdata[8];
      got.rx_byte    = m_axis_tdata[16:9];
      got.need_byte  = m_axis_tdata[17];
      got.done_res   = m_axis_tdata[18];
      got.error_code = err_e'(m_axis_tdata[20:19]);
      sb.check_result(got);
    end
  end

  // run limit
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    sb            = new();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // ignored words in idle, unknown kind, zero-length read
    offer_fields(REQ_STATUS, 7'h00, 8'h00, 16'd0, StStart, 8'h00, 8'h00);
    offer_fields(REQ_TICK, 7'h00, 8'h00, 16'd0, 8'h00, 8'h00, 8'h00);
    offer_fields(REQ_WBYTE, 7'h00, 8'h00, 16'd0, 8'h00, 8'h00, 8'h5A);
    offer_fields(3'd7, 7'h7F, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    offer_fields(REQ_READ, 7'h12, 8'h34, 16'd0, 8'h00, 8'h00, 8'h00);
    // zero-length write stops right after the register index
    offer_fields(REQ_WRITE, 7'h7F, 8'hFF, 16'd0, 8'h00, 8'h00, 8'h00);
    offer_fields(REQ_STATUS, 7'h00, 8'h00, 16'd0, StStart | 8'h07, 8'h00, 8'h00);
    offer_fields(REQ_STATUS, 7'h00, 8'h00, 16'd0, StAddrWAck, 8'h00, 8'h00);
    offer_fields(REQ_STATUS, 7'h00, 8'h00, 16'd0, StWDataAck, 8'h00, 8'h00);
    // two-byte read with a busy begin and a wrong status mixed in
    offer_fields(REQ_READ, 7'h00, 8'h00, 16'd2, 8'h00, 8'h00, 8'h00);
    offer_fields(REQ_STATUS, 7'h00, 8'h00, 16'd0, StStart, 8'h00, 8'h00);
    offer_fields(REQ_STATUS, 7'h00, 8'h00, 16'd0, StAddrWAck, 8'h00, 8'h00);
    offer_fields(REQ_STATUS, 7'h00, 8'h00, 16'd0, StWDataAck, 8'h00, 8'h00);
    offer_fields(REQ_STATUS, 7'h00, 8'h00, 16'd0, StRestart, 8'h00, 8'h00);
    offer_fields(REQ_WRITE, 7'h7F, 8'hFF, 16'hFFFF, 8'h00, 8'h00, 8'h00);
    offer_fields(REQ_STATUS, 7'h00, 8'h00, 16'd0, StAddrRAck, 8'h00, 8'h00);
    offer_fields(REQ_STATUS, 7'h00, 8'h00, 16'd0, StRDataNack, 8'h00, 8'h00);
    offer_fields(REQ_STATUS, 7'h00, 8'h00, 16'd0, StRDataAck, 8'hFF, 8'h00);
    offer_fields(REQ_STATUS, 7'h00, 8'h00, 16'd0, StRDataNack, 8'h00, 8'h00);
    // one-byte write through the host byte handshake
    offer_fields(REQ_WRITE, 7'h55, 8'hAA, 16'd1, 8'h00, 8'h00, 8'h00);
    offer_fields(REQ_STATUS, 7'h00, 8'h00, 16'd0, StStart, 8'h00, 8'h00);
    offer_fields(REQ_STATUS, 7'h00, 8'h00, 16'd0, StAddrWAck, 8'h00, 8'h00);
    offer_fields(REQ_STATUS, 7'h00, 8'h00, 16'd0, StWDataAck, 8'h00, 8'h00);
    offer_fields(REQ_WBYTE, 7'h00, 8'h00, 16'd0, 8'h00, 8'h00, 8'hFF);
    offer_fields(REQ_STATUS, 7'h00, 8'h00, 16'd0, StWDataAck, 8'h00, 8'h00);
    // timeout of zero aborts on the first tick
    write_timeout(16'd0);
    offer_fields(REQ_WRITE, 7'h2A, 8'h00, 16'hFFFF, 8'h00, 8'h00, 8'h00);
    offer_fields(REQ_TICK, 7'h00, 8'h00, 16'd0, 8'h00, 8'h00, 8'h00);

    // random transactions under several timeout settings
    foreach (timeout_plan[p]) begin
      write_timeout(timeout_plan[p]);
      idling = (p != 3);
      for (int i = 0; i < ItemsPerSetting; i++) begin
        if (p == 2 && i == 20) hold_off_req = 1'b1;
        if (p == 4 && i == ItemsPerSetting / 2) wait_for_results();
        offer_word(next_word());
      end
    end

    wait_for_results();
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
